>>> hdl/intsort_pkg.sv
// ----------------------------------------------------------------------------
// intsort_pkg
// Shared types and constants of the integer sorter: the transaction structs
// of both channels, the cell control and neighbor link structs.
// ----------------------------------------------------------------------------
`default_nettype none

package intsort_pkg;

  localparam int unsigned MaxItems = 64;
  localparam int unsigned CountW   = $clog2(MaxItems + 1);
  localparam int unsigned DataW    = 32;

  typedef struct packed {
    logic signed [DataW-1:0] value;
    logic                    last_item;
  } in_t;

  typedef struct packed {
    logic signed [DataW-1:0] sorted_value;
    logic                    end_of_block;
    logic                    overflowed;
  } out_t;

  // Control broadcast to every cell.
  typedef struct packed {
    logic insert;
    logic shift;
  } cell_cmd_t;

  // What one cell shows its neighbors.
  typedef struct packed {
    logic signed [DataW-1:0] value;
    logic                    valid;
    logic                    gt;     // cell moves on insert
  } cell_link_t;

endpackage

`default_nettype wire

>>> hdl/integer_sorter_core.sv
// ----------------------------------------------------------------------------
// integer_sorter_core
// Block sorter for signed 32-bit values built as an insertion chain of cells.
// ----------------------------------------------------------------------------
// Channel | Direction | Handshake               | Payload
// in      | input     | in_valid_i / in_stall_o | in_data_i  (value, last_item)
// out     | output    | out_valid_o/ out_stall_i| out_data_o (sorted_value,
//         |           |                         |   end_of_block, overflowed)
//
// Fill: one value per cycle enters the chain, in its sorted place at once.
// Drain: after the last value the chain shifts out one value per cycle, the
// smallest first; the input is stalled until the final result is taken.
// Reset empties the chain and the count; stalls on the output hold the chain.
// ----------------------------------------------------------------------------
`default_nettype none

module integer_sorter_core (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  intsort_pkg::in_t  in_data_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output intsort_pkg::out_t out_data_o
);
  import intsort_pkg::*;

  typedef enum logic [1:0] {
    S_FILL  = 2'b01,
    S_DRAIN = 2'b10
  } state_e;

  state_e            state_q, state_d;
  logic [CountW-1:0] count_q, count_d;
  logic              ovf_q, ovf_d;
  logic              in_acc, out_acc, full;
  cell_cmd_t         cmd;
  cell_link_t        links [MaxItems];

  assign in_stall_o  = (state_q != S_FILL);
  assign out_valid_o = (state_q == S_DRAIN);
  assign in_acc      = in_valid_i && !in_stall_o;
  assign out_acc     = out_valid_o && !out_stall_i;
  assign full        = (count_q == CountW'(MaxItems));

  // Drop the value when the chain is full.
  assign cmd.insert = in_acc && !full;
  assign cmd.shift  = out_acc;

  always_comb begin
    state_d = state_q;
    count_d = count_q;
    ovf_d   = ovf_q;
    unique case (state_q)
      S_FILL: begin
        if (in_acc) begin
          if (full) begin
            ovf_d = 1'b1;
          end else begin
            count_d = count_q + CountW'(1);
          end
          if (in_data_i.last_item) begin
            state_d = S_DRAIN;
          end
        end
      end
      S_DRAIN: begin
        if (out_acc) begin
          count_d = count_q - CountW'(1);
          if (count_q == CountW'(1)) begin
            state_d = S_FILL;
            ovf_d   = 1'b0;
          end
        end
      end
      default: begin
        state_d = S_FILL;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_FILL;
      count_q <= '0;
      ovf_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
      ovf_q   <= ovf_d;
    end
  end

  for (genvar i = 0; i < MaxItems; i++) begin : g_cell
    cell_link_t left, right;

    if (i == 0) begin : g_head
      assign left.value = '0;
      assign left.valid = 1'b1;
      assign left.gt    = 1'b0;
    end else begin : g_body
      assign left = links[i-1];
    end

    if (i == MaxItems - 1) begin : g_tail
      assign right.value = '0;
      assign right.valid = 1'b0;
      assign right.gt    = 1'b1;
    end else begin : g_next
      assign right = links[i+1];
    end

    intsort_cell u_cell (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .cmd_i       (cmd),
      .new_value_i (in_data_i.value),
      .left_i      (left),
      .right_i     (right),
      .self_o      (links[i])
    );
  end

  assign out_data_o.sorted_value = links[0].value;
  assign out_data_o.end_of_block = (count_q == CountW'(1));
  assign out_data_o.overflowed   = ovf_q;

endmodule

`default_nettype wire

>>> hdl/intsort_cell.sv
// ----------------------------------------------------------------------------
// intsort_cell
// One slot of the insertion chain. On insert, a slot whose value is greater
// than the new value moves right: it takes its left neighbor's value, or the
// new value if the left neighbor stays. On shift, it takes the right value.
// ----------------------------------------------------------------------------
`default_nettype none

module intsort_cell (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  intsort_pkg::cell_cmd_t cmd_i,
  input  logic signed [intsort_pkg::DataW-1:0] new_value_i,
  input  intsort_pkg::cell_link_t left_i,
  input  intsort_pkg::cell_link_t right_i,
  output intsort_pkg::cell_link_t self_o
);
  import intsort_pkg::*;

  logic signed [DataW-1:0] value_q, value_d;
  logic                    valid_q, valid_d;
  logic                    gt;

  // Empty slots count as greater, so a value above all stored ones fills the first empty slot.
  assign gt = !valid_q || (new_value_i < value_q);

  always_comb begin
    value_d = value_q;
    valid_d = valid_q;
    if (cmd_i.shift) begin
      value_d = right_i.value;
      valid_d = right_i.valid;
    end else if (cmd_i.insert && gt) begin
      value_d = left_i.gt ? left_i.value : new_value_i;
      valid_d = valid_q | left_i.valid;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    value_q <= value_d;
  end

  assign self_o.value = value_q;
  assign self_o.valid = valid_q;
  assign self_o.gt    = gt;

endmodule

`default_nettype wire
